>>> hw/rtl/lmdt_pkg.sv
package lmdt_pkg;

  localparam int LOOP_COUNT = 8;
  localparam int LOOP_W     = 3;
  localparam int SAMPLE_W   = 12;
  localparam int TIME_W     = 32;
  localparam int DELAY_W    = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int THR_REG_W  = 48;

  localparam logic [KIND_W-1:0] KIND_RAISED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEARED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CUT     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LEAK_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_EN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_HI   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_HI = 3'd5;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

>>> hw/rtl/lmdt_if.sv
interface lmdt_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [lmdt_pkg::LOOP_W-1:0]         loop_index;
  logic [lmdt_pkg::SAMPLE_W-1:0]       sample;
  logic [lmdt_pkg::TIME_W-1:0]         now_seconds;
  modport source (output valid, action, loop_index, sample, now_seconds, input ready);
  modport sink (input valid, action, loop_index, sample, now_seconds, output ready);
endinterface

interface lmdt_out_if;
  logic                                valid;
  logic                                ready;
  logic [lmdt_pkg::KIND_W-1:0]         event_kind;
  logic [lmdt_pkg::LOOP_W-1:0]         event_loop;
  logic                                last_of_run;
  modport source (output valid, event_kind, event_loop, last_of_run, input ready);
  modport sink (input valid, event_kind, event_loop, last_of_run, output ready);
endinterface

interface lmdt_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lmdt_pkg::CFG_IDX_W-1:0]      index;
  logic [lmdt_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/lmdt_alu.sv
module lmdt_alu (
  input  lmdt_pkg::alu_op_t             op,
  input  logic [lmdt_pkg::TIME_W-1:0]   a,
  input  logic [lmdt_pkg::TIME_W-1:0]   b,
  output logic [lmdt_pkg::TIME_W:0]     res
);

  // The top bit is the carry of an add or the borrow of a subtract.
  always_comb begin
    case (op)
      lmdt_pkg::ALU_ADD: res = {1'b0, a} + {1'b0, b};
      lmdt_pkg::ALU_SUB: res = {1'b0, a} - {1'b0, b};
      default:           res = {1'b0, a} + {1'b0, b};
    endcase
  end

endmodule

>>> hw/rtl/leak_monitor_delayed_trip_core.sv
// Leakage monitor with delayed trip for eight loops.
// Items arrive on in_if. A sample item (action 0) checks one loop against its
// threshold and yields at most one event, raised or cleared. A tick item
// (action 1) scans all loops and yields one cut command for each loop whose
// armed deadline has passed; last_of_run marks the final event of an item.
// Configuration is written on cfg_if, which is always ready; the user must write
// it only while idle, which the block itself does not enforce. A sample passes a
// compare state, and an add state when it arms a deadline; its event is loaded
// into out_if in the compare state. A tick scans all eight loops, one loop per cycle
// through the shared adder, then emits each cut command in turn, if any is due.
// The block takes one item at a time and in_if.ready is high only when idle.
// Results sit in a single output register; the block accepts a new item while
// it waits, and only stalls when a further event must be loaded.
// A synchronous active-low reset clears the state, configuration, output valid,
// leak flags and deadlines; the block is ready in the first cycle after reset.
module leak_monitor_delayed_trip_core (
  input  logic          clk,
  input  logic          rst_n,
  lmdt_in_if.sink       in_if,
  lmdt_out_if.source    out_if,
  lmdt_cfg_if.sink      cfg_if
);

  localparam int LC = lmdt_pkg::LOOP_COUNT;
  localparam int LW = lmdt_pkg::LOOP_W;
  localparam int TW = lmdt_pkg::TIME_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_ADD,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [LC-1:0]                      leak_en_r, leak_en_nxt;
  logic [LC-1:0]                      cut_en_r, cut_en_nxt;
  logic [lmdt_pkg::THR_REG_W-1:0]     thr_lo_r, thr_lo_nxt, thr_hi_r, thr_hi_nxt;
  logic [lmdt_pkg::CFG_DATA_W-1:0]    dly_lo_r, dly_lo_nxt, dly_hi_r, dly_hi_nxt;

  logic [LC-1:0]                      flag_r, flag_nxt;
  logic [TW-1:0]                      dl_r [LC];
  logic [TW-1:0]                      dl_nxt [LC];
  logic [LC-1:0]                      mask_r, mask_nxt;
  logic [LW-1:0]                      idx_r, idx_nxt;

  logic [LW-1:0]                      loop_r, loop_nxt;
  logic [lmdt_pkg::SAMPLE_W-1:0]      sample_r, sample_nxt;
  logic [TW-1:0]                      now_r, now_nxt;

  logic                               ov_r, ov_nxt;
  logic [lmdt_pkg::KIND_W-1:0]        okind_r, okind_nxt;
  logic [LW-1:0]                      oloop_r, oloop_nxt;
  logic                               olast_r, olast_nxt;

  lmdt_pkg::alu_op_t                  alu_op;
  logic [TW-1:0]                      alu_a, alu_b;
  logic [TW:0]                        alu_res;

  logic [lmdt_pkg::THR_REG_W-1:0]     thr_word;
  logic [lmdt_pkg::SAMPLE_W-1:0]      thr;
  logic [lmdt_pkg::CFG_DATA_W-1:0]    dly_word;
  logic [lmdt_pkg::DELAY_W-1:0]       dly;
  logic                               out_free;
  logic                               leaking;
  logic [LC-1:0]                      mask_rest;
  logic [LW-1:0]                      low_idx;

  lmdt_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign thr_word = loop_r[LW-1] ? thr_hi_r : thr_lo_r;
  assign thr      = thr_word[lmdt_pkg::SAMPLE_W*int'(loop_r[LW-2:0]) +: lmdt_pkg::SAMPLE_W];
  assign dly_word = loop_r[LW-1] ? dly_hi_r : dly_lo_r;
  assign dly      = dly_word[lmdt_pkg::DELAY_W*int'(loop_r[LW-2:0]) +: lmdt_pkg::DELAY_W];

  always_comb begin
    case (state_r)
      ST_CMP: begin
        alu_op = lmdt_pkg::ALU_SUB;
        alu_a  = TW'(thr);
        alu_b  = TW'(sample_r);
      end
      ST_SCAN: begin
        alu_op = lmdt_pkg::ALU_SUB;
        alu_a  = now_r;
        alu_b  = dl_r[idx_r];
      end
      default: begin
        alu_op = lmdt_pkg::ALU_ADD;
        alu_a  = now_r;
        alu_b  = TW'(dly);
      end
    endcase
  end

  assign leaking   = alu_res[TW];
  assign out_free  = !ov_r || out_if.ready;
  assign mask_rest = mask_r & (mask_r - LC'(1));

  always_comb begin
    low_idx = '0;
    for (int i = LC - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_idx = LW'(i);
      end
    end
  end

  assign in_if.ready        = (state_r == ST_IDLE);
  assign cfg_if.ready       = 1'b1;
  assign out_if.valid       = ov_r;
  assign out_if.event_kind  = okind_r;
  assign out_if.event_loop  = oloop_r;
  assign out_if.last_of_run = olast_r;

  always_comb begin
    state_nxt   = state_r;
    leak_en_nxt = leak_en_r;
    cut_en_nxt  = cut_en_r;
    thr_lo_nxt  = thr_lo_r;
    thr_hi_nxt  = thr_hi_r;
    dly_lo_nxt  = dly_lo_r;
    dly_hi_nxt  = dly_hi_r;
    flag_nxt    = flag_r;
    dl_nxt      = dl_r;
    mask_nxt    = mask_r;
    idx_nxt     = idx_r;
    loop_nxt    = loop_r;
    sample_nxt  = sample_r;
    now_nxt     = now_r;
    ov_nxt      = ov_r && !out_if.ready;
    okind_nxt   = okind_r;
    oloop_nxt   = oloop_r;
    olast_nxt   = olast_r;

    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        lmdt_pkg::REG_LEAK_EN:  leak_en_nxt = cfg_if.data[LC-1:0];
        lmdt_pkg::REG_CUT_EN:   cut_en_nxt  = cfg_if.data[LC-1:0];
        lmdt_pkg::REG_THR_LO:   thr_lo_nxt  = cfg_if.data[lmdt_pkg::THR_REG_W-1:0];
        lmdt_pkg::REG_THR_HI:   thr_hi_nxt  = cfg_if.data[lmdt_pkg::THR_REG_W-1:0];
        lmdt_pkg::REG_DELAY_LO: dly_lo_nxt  = cfg_if.data;
        lmdt_pkg::REG_DELAY_HI: dly_hi_nxt  = cfg_if.data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          loop_nxt   = in_if.loop_index;
          sample_nxt = in_if.sample;
          now_nxt    = in_if.now_seconds;
          idx_nxt    = '0;
          mask_nxt   = '0;
          state_nxt  = in_if.action ? ST_SCAN : ST_CMP;
        end
      end
      ST_CMP: begin
        if (({1'b0, loop_r} >= (LW + 1)'(LC)) || !leak_en_r[loop_r]) begin
          state_nxt = ST_IDLE;
        end else if (leaking && !flag_r[loop_r]) begin
          if (out_free) begin
            flag_nxt[loop_r] = 1'b1;
            ov_nxt    = 1'b1;
            okind_nxt = lmdt_pkg::KIND_RAISED;
            oloop_nxt = loop_r;
            olast_nxt = 1'b1;
            state_nxt = cut_en_r[loop_r] ? ST_ADD : ST_IDLE;
          end
        end else if (!leaking && flag_r[loop_r]) begin
          if (out_free) begin
            flag_nxt[loop_r] = 1'b0;
            ov_nxt    = 1'b1;
            okind_nxt = lmdt_pkg::KIND_CLEARED;
            oloop_nxt = loop_r;
            olast_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ADD: begin
        dl_nxt[loop_r] = alu_res[TW] ? '1 : alu_res[TW-1:0];
        state_nxt      = ST_IDLE;
      end
      ST_SCAN: begin
        if (leak_en_r[idx_r] && flag_r[idx_r] && cut_en_r[idx_r] &&
            (dl_r[idx_r] != '0) && !alu_res[TW]) begin
          mask_nxt[idx_r] = 1'b1;
          dl_nxt[idx_r]   = '0;
        end
        if (idx_r == LW'(LC - 1)) begin
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + LW'(1);
        end
      end
      ST_EMIT: begin
        if (mask_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = lmdt_pkg::KIND_CUT;
          oloop_nxt = low_idx;
          olast_nxt = (mask_rest == '0);
          mask_nxt  = mask_rest;
          if (mask_rest == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      leak_en_r <= '0;
      cut_en_r  <= '0;
      thr_lo_r  <= '0;
      thr_hi_r  <= '0;
      dly_lo_r  <= '0;
      dly_hi_r  <= '0;
      flag_r    <= '0;
      for (int i = 0; i < LC; i++) begin
        dl_r[i] <= '0;
      end
      mask_r    <= '0;
      idx_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      leak_en_r <= leak_en_nxt;
      cut_en_r  <= cut_en_nxt;
      thr_lo_r  <= thr_lo_nxt;
      thr_hi_r  <= thr_hi_nxt;
      dly_lo_r  <= dly_lo_nxt;
      dly_hi_r  <= dly_hi_nxt;
      flag_r    <= flag_nxt;
      dl_r      <= dl_nxt;
      mask_r    <= mask_nxt;
      idx_r     <= idx_nxt;
      ov_r      <= ov_nxt;
    end
    loop_r   <= loop_nxt;
    sample_r <= sample_nxt;
    now_r    <= now_nxt;
    okind_r  <= okind_nxt;
    oloop_r  <= oloop_nxt;
    olast_r  <= olast_nxt;
  end

endmodule

>>> hw/rtl/lmdt_checker.sv
module lmdt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_action,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [lmdt_pkg::KIND_W-1:0]       out_event_kind,
  input logic                              out_last_of_run
);

  // A pending item stays offered until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_kind == lmdt_pkg::KIND_RAISED ||
                   out_event_kind == lmdt_pkg::KIND_CLEARED ||
                   out_event_kind == lmdt_pkg::KIND_CUT))
    else $error("undefined event kind");

  // A sample causes one event at most, so it is always the last of its run.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != lmdt_pkg::KIND_CUT |-> out_last_of_run)
    else $error("sample event not marked as last");

  // A tick always occupies the block for the scan.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action |=> !in_ready)
    else $error("ready during tick scan");

endmodule

bind leak_monitor_delayed_trip_core lmdt_checker u_lmdt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .in_action       (in_if.action),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_event_kind  (out_if.event_kind),
  .out_last_of_run (out_if.last_of_run)
);
